// ----- rtl/hjg_pkg.sv -----
package hjg_pkg;

  localparam int unsigned MAX_SAMPLES  = 255;
  localparam int unsigned BASE_SAMPLES = 32;

  localparam int unsigned IN_W   = 64;
  localparam int unsigned OUT_W  = 96;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned RATIO_W = 12;
  localparam int unsigned RES_W   = 15;
  localparam int unsigned IDX_W   = 8;

  // shared serial divider
  localparam int unsigned DVD_W = 27;
  localparam int unsigned DVS_W = 15;
  localparam int unsigned LEN_W = 5;

  localparam logic [1:0] REG_RATIO  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_CNT,
    ST_MOD,
    ST_DIG,
    ST_HDIV,
    ST_XDIV,
    ST_YDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } div_req_t;

endpackage

// ----- rtl/hjg_div.sv -----
module hjg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hjg_pkg::div_req_t         req,
  input  logic [hjg_pkg::DVD_W-1:0] dvd,
  input  logic [hjg_pkg::DVS_W-1:0] dvs,
  output logic                      done,
  output logic [hjg_pkg::DVD_W-1:0] quo,
  output logic [hjg_pkg::DVS_W-1:0] rem
);
  import hjg_pkg::*;

  // restoring divider, one quotient bit per cycle; the dividend is
  // left-aligned and req.len bits are consumed from its top
  logic             busy_r;
  logic             done_r;
  logic [LEN_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   diff;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
    diff   = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - LEN_W'(1);
        if (cnt_r == LEN_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dvd;
      dvs_r <= dvs;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/halton_jitter_generator.sv -----
// channel  | dir | fields (low bit first)
// in_      | in  | tdata: proj_m20[31:0], proj_m21[63:32]
// out_     | out | tdata: new_m20[31:0], new_m21[63:32], jitter_x[79:64], jitter_y[95:80]
// cfg_     | in  | APB, 0x0 upscale_ratio_q8, 0x4 render_width, 0x8 render_height
//
// A shared bit-serial divider does the index modulo (9 steps), the base-3
// inverse and both clip offsets (27 steps each); the base-2 and base-3
// digits are extracted in 8 steps between the modulo and the inverse.
// in_tready is high only while idle; a finished result waits in the output
// register and only the next item's final transfer stalls on out_tready.
// rst_n is synchronous: control and config registers return to their reset values, index to 0.
module halton_jitter_generator #(
  parameter int unsigned MAX_SAMPLES  = hjg_pkg::MAX_SAMPLES,
  parameter int unsigned BASE_SAMPLES = hjg_pkg::BASE_SAMPLES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hjg_pkg::IN_W-1:0]   in_tdata,   // proj_m20, proj_m21
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hjg_pkg::OUT_W-1:0]  out_tdata,  // new_m20, new_m21, jitter_x, jitter_y
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hjg_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hjg_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hjg_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hjg_pkg::*;

  localparam logic [IDX_W-1:0] MAX_CNT  = IDX_W'(MAX_SAMPLES);
  localparam logic [31:0]      BASE_MUL = 32'(BASE_SAMPLES);

  state_t state_r, state_nxt;
  logic   launch_r;

  logic [RATIO_W-1:0] ratio_r;
  logic [RES_W-1:0]   width_r;
  logic [RES_W-1:0]   height_r;

  logic [IDX_W-1:0] sample_index_r;
  logic [23:0]      rsq_r;
  logic [IDX_W-1:0] count_r;

  logic [31:0] m20_r, m21_r;
  logic [7:0]  n2_r, n3_r, h2_r;
  logic [9:0]  num_r, den_r;
  logic [2:0]  dig_cnt_r;
  logic [15:0] jy_r;
  logic [31:0] new20_r, new21_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  div_req_t         div_req;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  logic             cfg_wr;
  logic             in_acc;
  logic             load_out;
  logic [15:0]      jx_w;
  logic [15:0]      absx, absy;
  logic [RES_W-1:0] dx, dy;
  logic [IDX_W:0]   idx_inc;
  logic [23:0]      rsq_c;
  logic [31:0]      cnt_prod;
  logic [15:0]      cnt_raw;
  logic [IDX_W-1:0] cnt_clamp;
  logic [15:0]      n3_prod;
  logic [7:0]       n3_q;
  logic [1:0]       n3_d;
  logic [11:0]      num3;
  logic [11:0]      den3;
  logic [IDX_W-1:0] n_next;

  function automatic logic [31:0] sat34(input logic [33:0] v);
    if (!v[33] && (v[32:31] != 2'b00)) begin
      sat34 = 32'h7FFF_FFFF;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      sat34 = 32'h8000_0000;
    end else begin
      sat34 = v[31:0];
    end
  endfunction

  function automatic logic [31:0] apply_off(input logic [31:0] m, input logic [24:0] q,
                                            input logic add);
    logic [33:0] me;
    logic [33:0] qe;
    me = {{2{m[31]}}, m};
    qe = {9'b0, q};
    apply_off = sat34(add ? me + qe : me - qe);
  endfunction

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    jx_w    = {~h2_r[7], h2_r[6:0], 8'h00};
    absx    = jx_w[15] ? 16'(~jx_w + 16'd1) : jx_w;
    absy    = jy_r[15] ? 16'(~jy_r + 16'd1) : jy_r;
    dx      = (width_r == '0) ? RES_W'(1) : width_r;
    dy      = (height_r == '0) ? RES_W'(1) : height_r;
    idx_inc = {1'b0, sample_index_r} + (IDX_W+1)'(1);
    n_next  = div_rem[IDX_W-1:0] + IDX_W'(1);

    rsq_c     = (rsq_r < 24'h01_0000) ? 24'h01_0000 : rsq_r;
    cnt_prod  = 32'(rsq_c) * BASE_MUL;
    cnt_raw   = cnt_prod[31:16];
    if (cnt_raw == 16'd0) begin
      cnt_clamp = IDX_W'(1);
    end else if (cnt_raw > 16'(MAX_CNT)) begin
      cnt_clamp = MAX_CNT;
    end else begin
      cnt_clamp = cnt_raw[IDX_W-1:0];
    end

    // n/3 by reciprocal, exact for 8-bit n
    n3_prod = 16'(n3_r) * 16'd171;
    n3_q    = {1'b0, n3_prod[15:9]};
    n3_d    = 2'(n3_r - 8'(n3_q * 8'd3));
    num3    = 12'(num_r) * 12'd3 + 12'(n3_d);
    den3    = 12'(den_r) * 12'd3;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_CNT;
      ST_CNT:  state_nxt = ST_MOD;
      ST_MOD:  if (div_done) state_nxt = ST_DIG;
      ST_DIG:  if (dig_cnt_r == 3'd7) state_nxt = ST_HDIV;
      ST_HDIV: if (div_done) state_nxt = ST_XDIV;
      ST_XDIV: if (div_done) state_nxt = ST_YDIV;
      ST_YDIV: if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    load_out      = (state_r == ST_OUT) && (!out_valid_r || out_tready);
    div_req.start = launch_r && (state_r inside {ST_MOD, ST_HDIV, ST_XDIV, ST_YDIV});
    div_req.len   = LEN_W'(DVD_W);
    div_dvd       = '0;
    div_dvs       = DVS_W'(1);
    case (state_r)
      ST_MOD: begin
        div_req.len = LEN_W'(IDX_W + 1);
        div_dvd     = {idx_inc, (DVD_W-IDX_W-1)'(0)};
        div_dvs     = DVS_W'(count_r);
      end
      ST_HDIV: begin
        div_dvd = {num_r, 17'b0} + DVD_W'(den_r);
        div_dvs = DVS_W'({den_r, 1'b0});
      end
      ST_XDIV: begin
        div_dvd = {2'b0, absx, 9'b0} + DVD_W'(dx[RES_W-1:1]);
        div_dvs = dx;
      end
      ST_YDIV: begin
        div_dvd = {2'b0, absy, 9'b0} + DVD_W'(dy[RES_W-1:1]);
        div_dvs = dy;
      end
      default: ;
    endcase
  end

  hjg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .dvd  (div_dvd),
    .dvs  (div_dvs),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      launch_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      sample_index_r <= '0;
      dig_cnt_r      <= '0;
      ratio_r        <= RATIO_W'(256);
      width_r        <= RES_W'(1920);
      height_r       <= RES_W'(1080);
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_MOD) && div_done) begin
        sample_index_r <= div_rem[IDX_W-1:0];
        dig_cnt_r      <= '0;
      end else if (state_r == ST_DIG) begin
        dig_cnt_r <= dig_cnt_r + 3'd1;
      end
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_RATIO:  ratio_r  <= cfg_pwdata[RATIO_W-1:0];
          REG_WIDTH:  width_r  <= cfg_pwdata[RES_W-1:0];
          REG_HEIGHT: height_r <= cfg_pwdata[RES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m20_r <= in_tdata[31:0];
      m21_r <= in_tdata[63:32];
    end
    if (state_r == ST_SQR) begin
      rsq_r <= 24'(ratio_r) * 24'(ratio_r);
    end
    if (state_r == ST_CNT) begin
      count_r <= cnt_clamp;
    end
    if ((state_r == ST_MOD) && div_done) begin
      n2_r  <= n_next;
      n3_r  <= n_next;
      h2_r  <= '0;
      num_r <= '0;
      den_r <= 10'd1;
    end
    if (state_r == ST_DIG) begin
      h2_r <= {h2_r[6:0], n2_r[0]};
      n2_r <= {1'b0, n2_r[7:1]};
      if (n3_r != 8'd0) begin
        num_r <= num3[9:0];
        den_r <= den3[9:0];
        n3_r  <= n3_q;
      end
    end
    if ((state_r == ST_HDIV) && div_done) begin
      jy_r <= {~div_quo[15], div_quo[14:0]};
    end
    if ((state_r == ST_XDIV) && div_done) begin
      new20_r <= apply_off(m20_r, div_quo[24:0], jx_w[15]);
    end
    if ((state_r == ST_YDIV) && div_done) begin
      new21_r <= apply_off(m21_r, div_quo[24:0], !jy_r[15]);
    end
    if (load_out) begin
      out_data_r <= {jy_r, jx_w, new21_r, new20_r};
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RATIO:  cfg_prdata = DATA_W'(ratio_r);
      REG_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/hjg_checker.sv -----
module hjg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [hjg_pkg::OUT_W-1:0]  out_tdata
);
  import hjg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && $stable(out_tdata))
    else $error("item accepted while busy or result changed early");

  // base-2 offsets of indices below 256 have no bits under 2^-8
  a_jx_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:64] == 8'h00)
    else $error("jitter_x off the base-2 grid");

endmodule

bind halton_jitter_generator hjg_checker u_hjg_checker (.*);
